>>> src/rrts_pkg.sv
`default_nettype none

package rrts_pkg;

   // field widths fixed by the item formats
   localparam int BURST_W    = 16;
   localparam int QUANTUM_W  = 16;
   localparam int TIME_W     = 32;
   localparam int SLOT_OUT_W = 4;
   localparam int STATUS_W   = 2;

   // slice length after reset
   localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd10;

   // request function codes
   localparam logic FUNC_ARRIVE = 1'b0;
   localparam logic FUNC_TICK   = 1'b1;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_ACCEPT    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_REJECT    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_IDLE_TICK = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_RAN       = 2'd3;

   // controller to datapath commands
   typedef struct packed {
      logic load;    // capture request, issue table read
      logic commit;  // update state, fill response register
      logic pop;     // response taken downstream
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic out_full;
   } dp_status_type;

endpackage

`default_nettype wire

>>> src/rrts_req_if.sv
`default_nettype none

interface rrts_req_if;
   logic                           valid;
   logic                           ready;
   logic                           func;
   logic [rrts_pkg::BURST_W-1:0]   burst;

   modport source (output valid, output func, output burst, input ready);
   modport sink   (input valid, input func, input burst, output ready);
endinterface

`default_nettype wire

>>> src/rrts_rsp_if.sv
`default_nettype none

interface rrts_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [rrts_pkg::STATUS_W-1:0]     status;
   logic [rrts_pkg::SLOT_OUT_W-1:0]   ran_index;
   logic [rrts_pkg::SLOT_OUT_W-1:0]   next_index;
   logic                              finished;
   logic [rrts_pkg::TIME_W-1:0]       finish_time;
   logic [rrts_pkg::TIME_W-1:0]       time_after;

   modport source (output valid, output status, output ran_index, output next_index,
                   output finished, output finish_time, output time_after, input ready);
   modport sink   (input valid, input status, input ran_index, input next_index,
                   input finished, input finish_time, input time_after, output ready);
endinterface

`default_nettype wire

>>> src/rrts_ctrl.sv
`default_nettype none

module rrts_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_ready,
   input  wire logic                    rsp_ready,
   input  wire rrts_pkg::dp_status_type status,
   output      rrts_pkg::ctrl_cmd_type  cmd
);

   localparam logic [0:0] ST_IDLE = 1'b0;
   localparam logic [0:0] ST_EXEC = 1'b1;

   logic [0:0] state_ff;
   logic [0:0] state_in;

   // handshake and commands
   always_comb begin
      req_ready  = (state_ff == ST_IDLE);
      cmd.load   = req_valid && req_ready;
      cmd.pop    = status.out_full && rsp_ready;
      cmd.commit = (state_ff == ST_EXEC) && (!status.out_full || rsp_ready);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.load) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (cmd.commit) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> src/rrts_dpath.sv
`default_nettype none

module rrts_dpath #(
   parameter int MAX_JOBS = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire rrts_pkg::ctrl_cmd_type                cmd,
   output      rrts_pkg::dp_status_type               status,
   input  wire logic                                  req_func,
   input  wire logic [rrts_pkg::BURST_W-1:0]          req_burst,
   input  wire logic                                  csr_we,
   input  wire logic [rrts_pkg::QUANTUM_W-1:0]        csr_wdata,
   output      logic                                  rsp_valid,
   output      logic [rrts_pkg::STATUS_W-1:0]         rsp_status,
   output      logic [rrts_pkg::SLOT_OUT_W-1:0]       rsp_ran_index,
   output      logic [rrts_pkg::SLOT_OUT_W-1:0]       rsp_next_index,
   output      logic                                  rsp_finished,
   output      logic [rrts_pkg::TIME_W-1:0]           rsp_finish_time,
   output      logic [rrts_pkg::TIME_W-1:0]           rsp_time_after
);

   localparam int IDX_W = $clog2(MAX_JOBS);
   localparam int CNT_W = $clog2(MAX_JOBS + 1);
   localparam int BW    = rrts_pkg::BURST_W;
   localparam int QW    = rrts_pkg::QUANTUM_W;
   localparam int TW    = rrts_pkg::TIME_W;
   localparam int OW    = rrts_pkg::SLOT_OUT_W;

   // lowest set bit of a mask as a slot number
   function automatic logic [IDX_W-1:0] lowest_index(input logic [MAX_JOBS-1:0] mask);
      logic [MAX_JOBS-1:0] iso;
      logic [IDX_W-1:0]    enc;
      iso = mask & (~mask + MAX_JOBS'(1));
      enc = '0;
      for (int i = 0; i < MAX_JOBS; i++) begin
         if (iso[i]) enc = enc | IDX_W'(i);
      end
      return enc;
   endfunction

   // low bits of a slot number for the response
   function automatic logic [OW-1:0] slot_out(input logic [IDX_W-1:0] v);
      logic [IDX_W+OW-1:0] w;
      w = {{OW{1'b0}}, v};
      return w[OW-1:0];
   endfunction

   // captured request and configuration
   logic                func_ff;
   logic [BW-1:0]       burst_ff;
   logic [QW-1:0]       quantum_ff;

   // scheduler state
   logic [MAX_JOBS-1:0] live_ff, live_in;
   logic [CNT_W-1:0]    arrived_ff, arrived_in;
   logic [CNT_W-1:0]    done_ff, done_in;
   logic [IDX_W-1:0]    cur_ff, cur_in;
   logic [QW-1:0]       slice_ff, slice_in;
   logic [TW-1:0]       time_ff, time_in;

   // remaining burst table
   logic [BW-1:0]       remaining_mem [MAX_JOBS];
   logic [BW-1:0]       rd_data_ff;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_addr;
   logic [BW-1:0]       mem_wdata;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [rrts_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [OW-1:0]       ran_ff, ran_in;
   logic [OW-1:0]       next_ff, next_in;
   logic                fin_ff, fin_in;
   logic [TW-1:0]       ftime_ff, ftime_in;
   logic [TW-1:0]       tafter_ff, tafter_in;

   // working terms
   logic                idle;
   logic                full;
   logic [IDX_W-1:0]    slot;
   logic [BW-1:0]       rem_dec;
   logic                job_done;
   logic                expired;
   logic [QW-1:0]       slice_dec;
   logic [TW-1:0]       time_inc;
   logic [MAX_JOBS-1:0] cand_hi, cand_lo;
   logic [IDX_W-1:0]    pick;

   assign status.out_full = rsp_valid_ff;

   // rotating search for the next live slot
   always_comb begin
      for (int i = 0; i < MAX_JOBS; i++) begin
         cand_hi[i] = live_ff[i] && (IDX_W'(i) > cur_ff);
         cand_lo[i] = live_ff[i] && (IDX_W'(i) < cur_ff);
      end
      priority if (|cand_hi) begin
         pick = lowest_index(cand_hi);
      end else if (|cand_lo) begin
         pick = lowest_index(cand_lo);
      end else begin
         pick = cur_ff;
      end
   end

   // per-request arithmetic
   always_comb begin
      idle      = (done_ff >= arrived_ff);
      full      = (arrived_ff >= CNT_W'(MAX_JOBS));
      slot      = arrived_ff[IDX_W-1:0];
      rem_dec   = rd_data_ff - BW'(1);
      job_done  = (rem_dec == '0);
      expired   = (slice_ff <= QW'(1));
      slice_dec = (slice_ff == '0) ? '0 : slice_ff - QW'(1);
      time_inc  = (time_ff == '1) ? time_ff : time_ff + TW'(1);
   end

   // state update and response on commit; pop clears the response
   always_comb begin
      live_in      = live_ff;
      arrived_in   = arrived_ff;
      done_in      = done_ff;
      cur_in       = cur_ff;
      slice_in     = slice_ff;
      time_in      = time_ff;
      mem_we       = 1'b0;
      mem_addr     = cur_ff;
      mem_wdata    = rem_dec;
      status_in    = status_ff;
      ran_in       = ran_ff;
      next_in      = next_ff;
      fin_in       = fin_ff;
      ftime_in     = ftime_ff;
      tafter_in    = tafter_ff;
      rsp_valid_in = rsp_valid_ff;

      if (cmd.pop) rsp_valid_in = 1'b0;

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         ran_in       = '0;
         fin_in       = 1'b0;
         ftime_in     = '0;
         if (func_ff == rrts_pkg::FUNC_ARRIVE) begin
            if (full || (burst_ff == '0)) begin
               status_in = rrts_pkg::STATUS_REJECT;
            end else begin
               status_in     = rrts_pkg::STATUS_ACCEPT;
               ran_in        = slot_out(slot);
               mem_we        = 1'b1;
               mem_addr      = slot;
               mem_wdata     = burst_ff;
               live_in[slot] = 1'b1;
               arrived_in    = arrived_ff + CNT_W'(1);
               if (idle) begin
                  cur_in   = slot;
                  slice_in = quantum_ff;
               end
            end
         end else if (idle) begin
            status_in = rrts_pkg::STATUS_IDLE_TICK;
            time_in   = time_inc;
         end else begin
            status_in = rrts_pkg::STATUS_RAN;
            ran_in    = slot_out(cur_ff);
            mem_we    = 1'b1;
            slice_in  = slice_dec;
            time_in   = time_inc;
            if (job_done) begin
               fin_in          = 1'b1;
               ftime_in        = time_inc;
               live_in[cur_ff] = 1'b0;
               done_in         = done_ff + CNT_W'(1);
               slice_in        = quantum_ff;
               cur_in          = pick;
            end else if (expired) begin
               slice_in = quantum_ff;
               cur_in   = pick;
            end
         end
         next_in   = slot_out(cur_in);
         tafter_in = time_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff   <= rrts_pkg::QUANTUM_RESET;
         live_ff      <= '0;
         arrived_ff   <= '0;
         done_ff      <= '0;
         cur_ff       <= '0;
         slice_ff     <= rrts_pkg::QUANTUM_RESET;
         time_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) quantum_ff <= csr_wdata;
         live_ff      <= live_in;
         arrived_ff   <= arrived_in;
         done_ff      <= done_in;
         cur_ff       <= cur_in;
         slice_ff     <= slice_in;
         time_ff      <= time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         burst_ff <= req_burst;
      end
      status_ff <= status_in;
      ran_ff    <= ran_in;
      next_ff   <= next_in;
      fin_ff    <= fin_in;
      ftime_ff  <= ftime_in;
      tafter_ff <= tafter_in;
   end

   // table: read current slot on capture, write back on commit
   always_ff @(posedge clock) begin
      if (cmd.load) rd_data_ff <= remaining_mem[cur_ff];
      if (mem_we) remaining_mem[mem_addr] <= mem_wdata;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_ran_index   = ran_ff;
   assign rsp_next_index  = next_ff;
   assign rsp_finished    = fin_ff;
   assign rsp_finish_time = ftime_ff;
   assign rsp_time_after  = tafter_ff;

endmodule

`default_nettype wire

>>> src/round_robin_time_slice_scheduler_unit.sv
// channel   dir   handshake                 payload
// req_ch    in    valid/ready               func, burst
// rsp_ch    out   valid/ready               status, ran_index, next_index, finished,
//                                           finish_time, time_after
// csr       in    csr_we, write only        csr_wdata (quantum)
//
// Each request is captured together with the table read, then committed.
// The burst table with its registered read sets this split into capture and commit.
// A result waits in the response register; the commit of the next request holds
// while that register is still full and rsp_ch.ready is low.
// Synchronous active-high reset; no clearing pass, the table is written before read.
`default_nettype none

module round_robin_time_slice_scheduler_unit #(
   parameter int MAX_JOBS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   rrts_req_if.sink                                 req_ch,
   rrts_rsp_if.source                               rsp_ch,
   input  wire logic                                csr_we,
   input  wire logic [rrts_pkg::QUANTUM_W-1:0]      csr_wdata
);

   rrts_pkg::ctrl_cmd_type  cmd;
   rrts_pkg::dp_status_type dp_status;
   logic                    req_ready;

   // sequencing
   rrts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ch.ready),
      .status    (dp_status),
      .cmd       (cmd)
   );

   assign req_ch.ready = req_ready;

   // scheduler state and table
   rrts_dpath #(
      .MAX_JOBS (MAX_JOBS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (dp_status),
      .req_func        (req_ch.func),
      .req_burst       (req_ch.burst),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_ch.valid),
      .rsp_status      (rsp_ch.status),
      .rsp_ran_index   (rsp_ch.ran_index),
      .rsp_next_index  (rsp_ch.next_index),
      .rsp_finished    (rsp_ch.finished),
      .rsp_finish_time (rsp_ch.finish_time),
      .rsp_time_after  (rsp_ch.time_after)
   );

endmodule

`default_nettype wire

>>> src/rrts_checker.sv
`default_nettype none

module rrts_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_ready,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [rrts_pkg::STATUS_W-1:0]     rsp_status,
   input wire logic [rrts_pkg::SLOT_OUT_W-1:0]   rsp_ran_index,
   input wire logic                              rsp_finished,
   input wire logic [rrts_pkg::TIME_W-1:0]       rsp_finish_time,
   input wire logic [rrts_pkg::TIME_W-1:0]       rsp_time_after
);

   // a waiting response is held
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // one request in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   // a finish only comes from a running tick and carries the new time
   a_finish_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished |->
         (rsp_status == rrts_pkg::STATUS_RAN) && (rsp_finish_time == rsp_time_after))
      else $error("finish without a run tick or with wrong time");

   // rejects and idle ticks carry no slot or finish
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == rrts_pkg::STATUS_REJECT) ||
                    (rsp_status == rrts_pkg::STATUS_IDLE_TICK)) |->
         !rsp_finished && (rsp_finish_time == '0) && (rsp_ran_index == '0))
      else $error("empty result carries slot or finish");

   // no response straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind round_robin_time_slice_scheduler_unit rrts_checker u_rrts_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_status      (rsp_ch.status),
   .rsp_ran_index   (rsp_ch.ran_index),
   .rsp_finished    (rsp_ch.finished),
   .rsp_finish_time (rsp_ch.finish_time),
   .rsp_time_after  (rsp_ch.time_after)
);

`default_nettype wire
